[hdl/lkv_pkg.sv]
package lkv_pkg;

  // Store geometry
  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 64;
  localparam int VALUE_BITS = 64;

  localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CntW = $clog2(ENTRIES + 1);
  localparam int CmpW = 9;

  // Port field widths
  localparam int FIELD_W = 64;
  localparam int CAP_W   = 5;

  // Configuration port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int CAP_RESET = 16;
  localparam logic CAP_REG = 1'b0;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [FIELD_W-1:0] lookup_key;
    logic [FIELD_W-1:0] write_value;
  } lkv_req_t;

  typedef struct packed {
    logic               hit;
    logic [FIELD_W-1:0] read_value;
  } lkv_rsp_t;

  typedef enum logic [1:0] {
    RANK_NONE   = 2'd0,
    RANK_TOUCH  = 2'd1,
    RANK_INSERT = 2'd2
  } rank_op_e;

  // Recency update request to the rank table
  typedef struct packed {
    rank_op_e        op;
    logic [IdxW-1:0] idx;
    logic [IdxW-1:0] rank;
  } rank_cmd_t;

  // Valid bit and rank of one entry
  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] rank;
  } rank_view_t;

endpackage

[hdl/lkv_ram.sv]
module lkv_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  parameter int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/lkv_rank.sv]
module lkv_rank (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lkv_pkg::rank_cmd_t       cmd_i,
  input  logic [lkv_pkg::IdxW-1:0] rd_idx_i,
  output lkv_pkg::rank_view_t      rd_view_o,
  output logic [lkv_pkg::CntW-1:0] count_o
);
  import lkv_pkg::*;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IdxW-1:0]    rank_q [ENTRIES];
  logic [IdxW-1:0]    rank_d [ENTRIES];
  logic [CntW-1:0]    count_q, count_d;

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    count_d = count_q;
    unique case (cmd_i.op)
      RANK_TOUCH: begin
        // Age every entry that was more recent than the touched one
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i] && (IdxW'(i) != cmd_i.idx) && (rank_q[i] < cmd_i.rank)) begin
            rank_d[i] = rank_q[i] + 1'b1;
          end
        end
        rank_d[cmd_i.idx] = '0;
      end
      RANK_INSERT: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i]) begin
            rank_d[i] = rank_q[i] + 1'b1;
          end
        end
        valid_d[cmd_i.idx] = 1'b1;
        rank_d[cmd_i.idx]  = '0;
        count_d            = count_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rank_q  <= '{default: '0};
      count_q <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      count_q <= count_d;
    end
  end

  assign rd_view_o.valid = valid_q[rd_idx_i];
  assign rd_view_o.rank  = rank_q[rd_idx_i];
  assign count_o         = count_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'($countones(valid_q)) == count_q)
    else $error("entry count differs from number of valid entries");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == RANK_INSERT) |-> !valid_q[cmd_i.idx])
    else $error("insert into an entry that is already valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == RANK_TOUCH) |-> (valid_q[cmd_i.idx] && (rank_q[cmd_i.idx] == cmd_i.rank)))
    else $error("touch of an invalid entry or with a stale rank");
`endif

endmodule

[hdl/lkv_cfg.sv]
module lkv_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lkv_pkg::PADDR_W-1:0] paddr,
  input  logic [lkv_pkg::PDATA_W-1:0] pwdata,
  output logic [lkv_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [lkv_pkg::CntW-1:0]    cap_eff_o
);
  import lkv_pkg::*;

  logic [CAP_W-1:0] cap_q, cap_d;
  logic             sel_cap;

  // One word per register: the word index sits above the byte offset
  assign sel_cap = (paddr[PADDR_W-1] == CAP_REG);

  always_comb begin
    cap_d = cap_q;
    if (psel && penable && pwrite && sel_cap) begin
      cap_d = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(CAP_RESET);
    end else begin
      cap_q <= cap_d;
    end
  end

  assign pready = 1'b1;
  assign prdata = sel_cap ? PDATA_W'(cap_q) : '0;

  // Zero behaves as one; clamp to the store depth
  always_comb begin
    priority if (cap_q == '0) begin
      cap_eff_o = CntW'(1);
    end else if (CmpW'(cap_q) > CmpW'(ENTRIES)) begin
      cap_eff_o = CntW'(ENTRIES);
    end else begin
      cap_eff_o = CntW'(cap_q);
    end
  end

endmodule

[hdl/lru_key_value_cache.sv]
// Channel   | Direction | Handshake                 | Payload
// request   | in        | in_valid_i / in_stall_o   | in_data_i  (mode, lookup_key, write_value)
// response  | out       | out_valid_o / out_stall_i | out_data_o (hit, read_value)
// config    | in        | psel/penable/pwrite/pready| paddr, pwdata, prdata (capacity at 0)
//
// A request is served by a linear scan of all ENTRIES keys (S_SCAN), then S_DECIDE, then
// S_RESP; a get that hits passes through S_VWAIT first. The next request is taken only once
// the response is loaded and the controller is back in S_IDLE. The key memory has one read
// port with a registered read, so the scan reads one stored key at a time.
// Reset clears the valid bits, ranks and count at once; no clearing pass is needed.
// A stalled response sits in the output register while the next request is scanned.
module lru_key_value_cache (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lkv_pkg::lkv_req_t           in_data_i,
  // response channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lkv_pkg::lkv_rsp_t           out_data_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lkv_pkg::PADDR_W-1:0] paddr,
  input  logic [lkv_pkg::PDATA_W-1:0] pwdata,
  output logic [lkv_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import lkv_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_VWAIT  = 5'b01000,
    S_RESP   = 5'b10000
  } state_e;

  // Running results of the key scan
  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] hit_idx;
    logic [IdxW-1:0] hit_rank;
    logic            free_found;
    logic [IdxW-1:0] free_idx;
    logic            any;
    logic [IdxW-1:0] worst_rank;
    logic [IdxW-1:0] worst_idx;
  } scan_t;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);
  localparam logic [CntW-1:0] Depth   = CntW'(ENTRIES);

  state_e          state_q, state_d;
  scan_t           scan_q, scan_d;
  lkv_req_t        req_q, req_d;
  lkv_rsp_t        res_q, res_d;
  lkv_rsp_t        out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic [CntW-1:0] issue_q, issue_d;
  logic            rd_vld_q, rd_vld_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;

  logic                  accept;
  logic                  load_out;
  logic [CntW-1:0]       cap_eff;
  logic [CntW-1:0]       count;
  rank_view_t            view;
  rank_cmd_t             rank_cmd;
  logic [KEY_BITS-1:0]   key_rdata;
  logic [VALUE_BITS-1:0] val_rdata;
  logic                  key_re, key_we, val_re, val_we;
  logic [IdxW-1:0]       wr_idx;
  logic                  entry_match;

  lkv_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cap_eff_o (cap_eff)
  );

  lkv_rank u_rank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (rank_cmd),
    .rd_idx_i  (rd_idx_q),
    .rd_view_o (view),
    .count_o   (count)
  );

  lkv_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (KEY_BITS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (wr_idx),
    .wdata_i (req_q.lookup_key[KEY_BITS-1:0]),
    .re_i    (key_re),
    .raddr_i (issue_q[IdxW-1:0]),
    .rdata_o (key_rdata)
  );

  lkv_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (VALUE_BITS)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (wr_idx),
    .wdata_i (req_q.write_value[VALUE_BITS-1:0]),
    .re_i    (val_re),
    .raddr_i (scan_q.hit_idx),
    .rdata_o (val_rdata)
  );

  // One request in flight: taking requests only when idle is the interlock that
  // keeps a scan from reading an entry that the previous request still writes.
  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign load_out = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);

  assign entry_match = view.valid && (key_rdata == req_q.lookup_key[KEY_BITS-1:0]);

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    issue_d     = issue_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    key_re      = 1'b0;
    key_we      = 1'b0;
    val_re      = 1'b0;
    val_we      = 1'b0;
    wr_idx      = scan_q.hit_idx;
    rank_cmd    = '{op: RANK_NONE, idx: scan_q.hit_idx, rank: scan_q.hit_rank};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d   = in_data_i;
          scan_d  = '0;
          issue_d = '0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue one key read per cycle; compare each key when its registered read returns
        if (issue_q != Depth) begin
          key_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = issue_q[IdxW-1:0];
          issue_d  = issue_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (entry_match && !scan_q.found) begin
            scan_d.found    = 1'b1;
            scan_d.hit_idx  = rd_idx_q;
            scan_d.hit_rank = view.rank;
          end
          if (!view.valid && !scan_q.free_found) begin
            scan_d.free_found = 1'b1;
            scan_d.free_idx   = rd_idx_q;
          end
          if (view.valid && (!scan_q.any || (view.rank > scan_q.worst_rank))) begin
            scan_d.any        = 1'b1;
            scan_d.worst_rank = view.rank;
            scan_d.worst_idx  = rd_idx_q;
          end
          if (rd_idx_q == LastIdx) begin
            state_d = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        res_d   = '{hit: scan_q.found, read_value: '0};
        state_d = S_RESP;
        priority if (scan_q.found) begin
          // Hit: refresh recency; a get reads the value, a put overwrites it
          rank_cmd.op = RANK_TOUCH;
          if (req_q.mode == MODE_GET) begin
            val_re  = 1'b1;
            state_d = S_VWAIT;
          end else begin
            val_we = 1'b1;
          end
        end else if (req_q.mode == MODE_PUT) begin
          if (CmpW'(count) >= CmpW'(cap_eff)) begin
            // Full: replace the least recent entry
            if (scan_q.any) begin
              wr_idx        = scan_q.worst_idx;
              key_we        = 1'b1;
              val_we        = 1'b1;
              rank_cmd.op   = RANK_TOUCH;
              rank_cmd.idx  = scan_q.worst_idx;
              rank_cmd.rank = scan_q.worst_rank;
            end
          end else if (scan_q.free_found) begin
            wr_idx       = scan_q.free_idx;
            key_we       = 1'b1;
            val_we       = 1'b1;
            rank_cmd.op  = RANK_INSERT;
            rank_cmd.idx = scan_q.free_idx;
          end
        end
      end

      S_VWAIT: begin
        res_d   = '{hit: 1'b1, read_value: FIELD_W'(val_rdata)};
        state_d = S_RESP;
      end

      S_RESP: begin
        // Hold until the output register is free
        if (load_out) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      issue_q     <= '0;
      scan_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rd_vld_q    <= rd_vld_d;
      issue_q     <= issue_d;
      scan_q      <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    res_q    <= res_d;
    out_q    <= out_d;
    rd_idx_q <= rd_idx_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_SCAN))
    else $error("accepted request did not start a scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (out_valid_q && (out_q.hit == $past(res_q.hit))))
    else $error("finished response was not loaded into the output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled response changed or was dropped");
`endif

endmodule
